// File: design/utf8_validating_decoder_core_macros.svh
// Assertion macros shared by the UTF-8 decoder checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef UTF8_VALIDATING_DECODER_CORE_MACROS_SVH
`define UTF8_VALIDATING_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8V_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("utf8v assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UTF8V_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("utf8v assertion failed");

`endif

// File: design/utf8v_pkg.sv
// Shared types and byte constants for the UTF-8 validating decoder.
// No dependencies; imported by every RTL module of the block.
package utf8v_pkg;

  typedef struct packed {
    logic [20:0] code_point;
    logic        valid_res;
    logic [2:0]  byte_count;
  } result_t;

  localparam logic [7:0] LeadMin    = 8'hC2;
  localparam logic [7:0] LeadMax    = 8'hF4;
  localparam logic [7:0] LeadE0     = 8'hE0;
  localparam logic [7:0] LeadEd     = 8'hED;
  localparam logic [7:0] LeadEf     = 8'hEF;
  localparam logic [7:0] LeadF0     = 8'hF0;
  localparam logic [7:0] LeadF4     = 8'hF4;
  localparam logic [7:0] ContLo     = 8'h80;
  localparam logic [7:0] ContBf     = 8'hBF;
  localparam logic [7:0] ContBe     = 8'hBE;
  localparam logic [7:0] ContB7     = 8'hB7;
  localparam logic [7:0] ContB0     = 8'hB0;
  localparam logic [7:0] Cont8f     = 8'h8F;
  localparam logic [7:0] Cont9f     = 8'h9F;
  localparam logic [7:0] ContA0     = 8'hA0;
  localparam logic [7:0] Cont90     = 8'h90;
  localparam logic [3:0] NibbleFull = 4'hF;

endpackage

// File: design/utf8v_check.sv
// Validation and code point assembly for one complete sequence.
// Pure combinational logic; depends on utf8v_pkg.
module utf8v_check (
  input  logic [2:0]        len_i,
  input  logic [7:0]        lead_i,
  input  logic [7:0]        f0_i,
  input  logic [7:0]        f1_i,
  input  logic [7:0]        f2_i,
  output utf8v_pkg::result_t res_o
);
  import utf8v_pkg::*;

  logic        ok;
  logic [20:0] cp;
  logic        cont0, cont1, cont2;

  assign cont0 = (f0_i[7:6] == 2'b10);
  assign cont1 = (f1_i[7:6] == 2'b10);
  assign cont2 = (f2_i[7:6] == 2'b10);

  always_comb begin
    ok = 1'b1;
    if (len_i == 3'd0 || len_i > 3'd4) ok = 1'b0;
    if (len_i >= 3'd2 && !cont0) ok = 1'b0;
    if (len_i >= 3'd3 && !cont1) ok = 1'b0;
    if (len_i == 3'd4 && !cont2) ok = 1'b0;
    // plane-final noncharacters xFFFE and xFFFF
    if (len_i == 3'd4 && (f2_i == ContBf || f2_i == ContBe) && f1_i == ContBf &&
        f0_i[3:0] == NibbleFull) ok = 1'b0;
    if (len_i >= 3'd2) begin
      unique case (lead_i)
        LeadE0: if (f0_i < ContA0) ok = 1'b0;
        LeadEd: if (f0_i > Cont9f) ok = 1'b0;
        LeadEf: begin
          if (f0_i == ContB7 && f1_i > Cont8f && f1_i < ContB0) ok = 1'b0;
          if (f0_i == ContBf && (f1_i == ContBe || f1_i == ContBf)) ok = 1'b0;
        end
        LeadF0: if (f0_i < Cont90) ok = 1'b0;
        LeadF4: if (f0_i > Cont8f) ok = 1'b0;
        default: ;
      endcase
    end
    if (lead_i >= ContLo && lead_i < LeadMin) ok = 1'b0;
    if (lead_i > LeadMax) ok = 1'b0;
  end

  always_comb begin
    unique case (len_i)
      3'd2:    cp = {10'd0, lead_i[4:0], f0_i[5:0]};
      3'd3:    cp = {5'd0, lead_i[3:0], f0_i[5:0], f1_i[5:0]};
      3'd4:    cp = {lead_i[2:0], f0_i[5:0], f1_i[5:0], f2_i[5:0]};
      default: cp = {13'd0, lead_i};
    endcase
  end

  always_comb begin
    res_o.code_point = ok ? cp : 21'd0;
    res_o.valid_res  = ok;
    res_o.byte_count = len_i;
  end

endmodule

// File: design/utf8v_seq.sv
// Sequence tracker: holds the lead byte, continuation bytes and counts.
// Depends on utf8v_pkg and utf8v_check.
module utf8v_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         byte_i,
  output logic               emit_o,
  output utf8v_pkg::result_t res_o
);
  import utf8v_pkg::*;

  logic [7:0] lead_q, lead_d;
  logic [2:0] exp_q, exp_d;
  logic [2:0] seen_q, seen_d;
  logic [7:0] fol_q [3];
  logic [7:0] fm [3];
  logic       idle;
  logic [2:0] lead_len;
  logic [2:0] seen_inc;
  logic [2:0] chk_len;
  logic [7:0] chk_lead;

  assign idle     = (exp_q == 3'd0);
  assign seen_inc = seen_q + 3'd1;

  always_comb begin
    priority if (byte_i < 8'hC0) lead_len = 3'd1;
    else if (byte_i < 8'hE0)     lead_len = 3'd2;
    else if (byte_i < 8'hF0)     lead_len = 3'd3;
    else if (byte_i < 8'hF8)     lead_len = 3'd4;
    else if (byte_i < 8'hFC)     lead_len = 3'd5;
    else if (byte_i < 8'hFE)     lead_len = 3'd6;
    else                         lead_len = 3'd1;
  end

  // merge the current beat into the held continuations
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fm[i] = (seen_q == 3'(i + 1)) ? byte_i : fol_q[i];
    end
  end

  assign chk_len  = idle ? 3'd1 : exp_q;
  assign chk_lead = idle ? byte_i : lead_q;

  utf8v_check u_check (
    .len_i  (chk_len),
    .lead_i (chk_lead),
    .f0_i   (fm[0]),
    .f1_i   (fm[1]),
    .f2_i   (fm[2]),
    .res_o  (res_o)
  );

  assign emit_o = accept_i && (idle ? (lead_len == 3'd1) : (seen_inc >= exp_q));

  always_comb begin
    lead_d = lead_q;
    exp_d  = exp_q;
    seen_d = seen_q;
    if (accept_i) begin
      if (idle) begin
        if (lead_len != 3'd1) begin
          lead_d = byte_i;
          exp_d  = lead_len;
          seen_d = 3'd1;
        end
      end else if (seen_inc >= exp_q) begin
        exp_d  = 3'd0;
        seen_d = 3'd0;
      end else begin
        seen_d = seen_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= 8'd0;
      exp_q  <= 3'd0;
      seen_q <= 3'd0;
    end else begin
      lead_q <= lead_d;
      exp_q  <= exp_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !idle) begin
      for (int i = 0; i < 3; i++) begin
        if (seen_q == 3'(i + 1)) fol_q[i] <= byte_i;
      end
    end
  end

endmodule

// File: design/utf8v_outbuf.sv
// Two-entry output register with skid stage for decoded results.
// Depends on utf8v_pkg.
module utf8v_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  utf8v_pkg::result_t data_i,
  output logic               space_o,
  output logic               valid_o,
  input  logic               ready_i,
  output utf8v_pkg::result_t data_o
);
  import utf8v_pkg::*;

  result_t main_q, skid_q;
  logic    main_v_q, skid_v_q;
  logic    pop;

  assign pop     = main_v_q && ready_i;
  assign space_o = !skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= push_i;
      end
    end else if (push_i) begin
      if (main_v_q) skid_v_q <= 1'b1;
      else          main_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) main_q <= skid_q;
      else if (push_i) main_q <= data_i;
    end else if (push_i) begin
      // park the beat in the skid stage while the head is stalled
      if (main_v_q) skid_q <= data_i;
      else          main_q <= data_i;
    end
  end

endmodule

// File: design/utf8_validating_decoder_core.sv
// UTF-8 validating decoder: one byte per beat, one result per sequence.
// Each result is registered in the output buffer (head, or skid when stalled).
// Throughput: one byte per cycle while the skid stage is free; a two-entry
// output buffer keeps input ready while a single result waits downstream.
// Reset clears the sequence state and empties the output buffer.
module utf8_validating_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] code_point_o,
  output logic        valid_res_o,
  output logic [2:0]  byte_count_o
);
  import utf8v_pkg::*;

  logic    accept;
  logic    emit;
  result_t seq_res;
  result_t out_res;

  assign accept = in_valid_i && in_ready_o;

  utf8v_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (data_byte_i),
    .emit_o   (emit),
    .res_o    (seq_res)
  );

  utf8v_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .data_i  (seq_res),
    .space_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  assign code_point_o = out_res.code_point;
  assign valid_res_o  = out_res.valid_res;
  assign byte_count_o = out_res.byte_count;

endmodule

// File: design/utf8v_checker.sv
// Port-level checker for the UTF-8 validating decoder, bound to the top.
// Depends on utf8_validating_decoder_core_macros.svh.
`include "utf8_validating_decoder_core_macros.svh"

module utf8v_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  data_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [20:0] code_point_o,
  input logic        valid_res_o,
  input logic [2:0]  byte_count_o
);

  logic        cp_in_range;
  logic        out_stall;
  logic [24:0] out_beat;

  // scalar value: at most U+10FFFF and outside the surrogate block
  assign cp_in_range = code_point_o <= 21'h10FFFF &&
                       (code_point_o < 21'h00D800 || code_point_o > 21'h00DFFF);
  assign out_stall   = out_valid_o && !out_ready_i;
  assign out_beat    = {code_point_o, valid_res_o, byte_count_o};

  `UTF8V_ASSERT_SAME(a_bad_is_zero, clk_i, rst_ni, out_valid_o && !valid_res_o, code_point_o == 0)
  `UTF8V_ASSERT_SAME(a_scalar_range, clk_i, rst_ni, out_valid_o && valid_res_o, cp_in_range)
  `UTF8V_ASSERT_SAME(a_count_range, clk_i, rst_ni, out_valid_o, byte_count_o != 3'd0 && byte_count_o <= 3'd6)
  `UTF8V_ASSERT_SAME(a_stall_means_full, clk_i, rst_ni, !in_ready_o, out_valid_o)
  `UTF8V_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_beat))

endmodule

bind utf8_validating_decoder_core utf8v_checker u_utf8v_checker (.*);

// File: tb/utf8_validating_decoder_core_tb.sv
// Self-checking testbench for the UTF-8 validating decoder core.
// Depends on utf8v_pkg and utf8_validating_decoder_core; a local decoder model
// predicts every result, which is checked field by field as it leaves.
module utf8_validating_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8v_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [20:0] code_point_o;
  logic        valid_res_o;
  logic [2:0]  byte_count_o;

  // Decoder state mirrored from the block
  logic [7:0]  seq_lead = 8'h00;
  logic [7:0]  seq_follow [3] = '{8'h00, 8'h00, 8'h00};
  logic [2:0]  seq_len_q = 3'd0;
  logic [2:0]  seq_count = 3'd0;

  result_t     decoded_q [$];
  logic [7:0]  seq_buf [$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_len = 0;
  bit          hold_flip = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;

  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_checked = 0;
  int unsigned valid_predicted = 0;
  int unsigned invalid_predicted = 0;

  utf8_validating_decoder_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_point_o (code_point_o),
    .valid_res_o  (valid_res_o),
    .byte_count_o (byte_count_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    if (b < 8'hC0) return 3'd1;
    if (b < 8'hE0) return 3'd2;
    if (b < 8'hF0) return 3'd3;
    if (b < 8'hF8) return 3'd4;
    if (b < 8'hFC) return 3'd5;
    if (b < 8'hFE) return 3'd6;
    return 3'd1;
  endfunction

  function automatic bit sequence_ok(input logic [2:0] len, input logic [7:0] lead);
    if (len == 3'd0 || len > 3'd4) return 1'b0;
    for (int i = 1; i < len; i++) begin
      if (seq_follow[i-1] < ContLo || seq_follow[i-1] > ContBf) return 1'b0;
    end
    // plane-end noncharacters xFFFE and xFFFF in the four-byte range
    if (len == 3'd4 && (seq_follow[2] == ContBf || seq_follow[2] == ContBe) &&
        seq_follow[1] == ContBf && seq_follow[0][3:0] == NibbleFull) return 1'b0;
    if (len >= 3'd2) begin
      case (lead)
        LeadE0: if (seq_follow[0] < ContA0) return 1'b0;
        LeadEd: if (seq_follow[0] > Cont9f) return 1'b0;
        LeadEf: begin
          if (seq_follow[0] == ContB7 && seq_follow[1] > Cont8f &&
              seq_follow[1] < ContB0) return 1'b0;
          if (seq_follow[0] == ContBf &&
              (seq_follow[1] == ContBe || seq_follow[1] == ContBf)) return 1'b0;
        end
        LeadF0: if (seq_follow[0] < Cont90) return 1'b0;
        LeadF4: if (seq_follow[0] > Cont8f) return 1'b0;
        default: ;
      endcase
    end
    if (lead >= ContLo && lead < LeadMin) return 1'b0;
    if (lead > LeadMax) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [20:0] assemble_cp(input logic [2:0] len, input logic [7:0] lead);
    logic [31:0] cp;
    case (len)
      3'd2:    cp = {27'd0, lead[4:0]};
      3'd3:    cp = {28'd0, lead[3:0]};
      3'd4:    cp = {29'd0, lead[2:0]};
      default: return {13'd0, lead};
    endcase
    for (int i = 1; i < len; i++) cp = (cp << 6) | {26'd0, seq_follow[i-1][5:0]};
    return cp[20:0];
  endfunction

  function automatic void push_result(input logic [2:0] len, input logic [7:0] lead);
    result_t r;
    r.valid_res  = sequence_ok(len, lead);
    r.code_point = r.valid_res ? assemble_cp(len, lead) : 21'd0;
    r.byte_count = len;
    if (r.valid_res) valid_predicted++;
    else invalid_predicted++;
    decoded_q.push_back(r);
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    if (seq_len_q == 3'd0) begin
      if (lead_length(b) == 3'd1) begin
        push_result(3'd1, b);
        return;
      end
      seq_lead  = b;
      seq_len_q = lead_length(b);
      seq_count = 3'd1;
      return;
    end
    // any byte inside an open sequence counts towards it
    if (seq_count >= 3'd1 && seq_count <= 3'd3) seq_follow[seq_count-1] = b;
    seq_count = seq_count + 3'd1;
    if (seq_count >= seq_len_q || seq_count == 3'd0) begin
      push_result(seq_len_q, seq_lead);
      seq_len_q = 3'd0;
      seq_count = 3'd0;
    end
  endfunction

  // ------------------------------------------------------------ result check

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected beat, got cp=%h valid=%b count=%0d", $time,
                 code_point_o, valid_res_o, byte_count_o);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        results_checked++;
        if (code_point_o !== want.code_point) begin
          $display("%0t: code_point expected %h got %h", $time,
                   want.code_point, code_point_o);
          fail_count++;
        end
        if (valid_res_o !== want.valid_res) begin
          $display("%0t: valid_res expected %b got %b", $time,
                   want.valid_res, valid_res_o);
          fail_count++;
        end
        if (byte_count_o !== want.byte_count) begin
          $display("%0t: byte_count expected %0d got %0d", $time,
                   want.byte_count, byte_count_o);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold when the test flips hold_flip
  always @(negedge clk_i) begin
    if (hold_flip != hold_seen) begin
      hold_seen   <= hold_flip;
      hold_left   <= hold_len;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, decoded_q.size());
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  // Called at a falling edge; returns at a falling edge with valid low.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i  = 1'b1;
    data_byte_i = b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_byte(b);
    bytes_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_seq();
    while (seq_buf.size() != 0) send_byte(seq_buf.pop_front());
  endtask

  task automatic wait_drained();
    while (decoded_q.size() != 0) @(negedge clk_i);
  endtask

  // Encode cp with a forced length, so overlong forms come out too.
  function automatic void encode_cp(input logic [20:0] cp, input int unsigned len);
    seq_buf.delete();
    case (len)
      1: seq_buf.push_back({1'b0, cp[6:0]});
      2: begin
        seq_buf.push_back({3'b110, cp[10:6]});
        seq_buf.push_back({2'b10, cp[5:0]});
      end
      3: begin
        seq_buf.push_back({4'b1110, cp[15:12]});
        seq_buf.push_back({2'b10, cp[11:6]});
        seq_buf.push_back({2'b10, cp[5:0]});
      end
      default: begin
        seq_buf.push_back({5'b11110, cp[20:18]});
        seq_buf.push_back({2'b10, cp[17:12]});
        seq_buf.push_back({2'b10, cp[11:6]});
        seq_buf.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void pick_sequence();
    int unsigned pick;
    int unsigned len;
    int unsigned idx;
    logic [20:0] cp;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // code point from the range of a random length (may hit surrogates), U+10FFFD now and then
      len = $urandom_range(1, 4);
      case (len)
        1: cp = 21'($urandom_range(0, 'h7F));
        2: cp = 21'($urandom_range('h80, 'h7FF));
        3: cp = 21'($urandom_range('h800, 'hFFFF));
        default: cp = ($urandom_range(3) == 0) ? 21'h10FFFD
                                               : 21'($urandom_range('h10000, 'h10FFFF));
      endcase
      encode_cp(cp, len);
    end else if (pick < 53) begin
      if ($urandom_range(1)) encode_cp(21'hFDD0 + 21'($urandom_range(31)), 3);
      else begin
        cp = {5'($urandom_range(16)), 16'hFFFE} | 21'($urandom_range(1));
        encode_cp(cp, (cp > 21'hFFFF) ? 4 : 3);
      end
    end else if (pick < 58) begin
      encode_cp(21'($urandom_range('hD800, 'hDFFF)), 3);
    end else if (pick < 64) begin
      // overlong: a value short enough for fewer bytes
      len = $urandom_range(2, 4);
      case (len)
        2: cp = 21'($urandom_range(0, 'h7F));
        3: cp = 21'($urandom_range(0, 'h7FF));
        default: cp = 21'($urandom_range(0, 'hFFFF));
      endcase
      encode_cp(cp, len);
    end else if (pick < 69) begin
      encode_cp(21'($urandom_range('h110000, 'h1FFFFF)), 4);
    end else if (pick < 78) begin
      // broken sequence: spoil one trailing byte, sometimes with a zero
      encode_cp(21'($urandom_range('h80, 'h10FFFF)), $urandom_range(2, 4));
      idx = $urandom_range(1, seq_buf.size() - 1);
      seq_buf[idx] = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
    end else if (pick < 85) begin
      seq_buf.delete();
      seq_buf.push_back(8'($urandom_range('hF8, 'hFD)));
      len = 32'(lead_length(seq_buf[0]));
      for (int i = 1; i < len; i++) begin
        seq_buf.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                    : {2'b10, 6'($urandom_range(63))});
      end
    end else begin
      seq_buf.delete();
      seq_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic random_burst(input int unsigned n_bytes);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick_sequence();
      send_seq();
    end
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_directed_edges();
    logic [7:0] edges [$];
    edges = '{8'h00, 8'h7F, 8'h80, 8'hFF,
              8'hC2, 8'h80,
              8'hDF, 8'hBF,
              8'hE0, 8'h9F, 8'hBF,
              8'hED, 8'hA0, 8'h80,
              8'hF4, 8'h90, 8'h80, 8'h80,
              8'hF8, 8'h80, 8'h80, 8'h80, 8'h80};
    send_idle_pct = 0;
    stall_pct     = 0;
    foreach (edges[i]) send_byte(edges[i]);
    wait_drained();
  endtask

  // Hold the receiver off while single-byte results keep arriving, so the
  // output buffer fills and input ready drops.
  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_len      = 80;
    @(posedge clk_i);
    hold_flip = ~hold_flip;
    @(negedge clk_i);
    for (int i = 0; i < 30; i++) send_byte(8'($urandom_range(0, 'h7F)));
    wait_drained();
  endtask

  task automatic test_random_streams();
    int unsigned idle_sets [4][2];
    idle_sets = '{'{0, 0}, '{65, 0}, '{0, 65}, '{38, 38}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_sets[p][0];
      stall_pct     = idle_sets[p][1];
      random_burst(105);
      // pause the sender until every outstanding result is out
      wait_drained();
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_edges();
    test_backpressure_fill();
    test_random_streams();

    send_idle_pct = 0;
    stall_pct     = 0;
    wait_drained();
    repeat (12) @(negedge clk_i);

    $display("Run: %0d bytes in, %0d results checked (%0d valid, %0d invalid)",
             bytes_sent, results_checked, valid_predicted, invalid_predicted);
    $display("Covered edge bytes, overlong, surrogate, noncharacter, 5/6-byte leads, stalls");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/utf8v_pkg.sv
design/utf8v_check.sv
design/utf8v_seq.sv
design/utf8v_outbuf.sv
design/utf8_validating_decoder_core.sv
design/utf8v_checker.sv
tb/utf8_validating_decoder_core_tb.sv
